@@ design/unicycle_pose_integrator_defines.svh @@
// ----------------------------------------------------------------------------
// Unicycle pose integrator assertion macros
// Short forms for the concurrent checks on the top level ports.
// ----------------------------------------------------------------------------
`ifndef UNICYCLE_POSE_INTEGRATOR_DEFINES_SVH
`define UNICYCLE_POSE_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define UPI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define UPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define UPI_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/upi_pkg.sv @@
// ----------------------------------------------------------------------------
// Unicycle pose integrator package
// Payload types, item kinds, controller codes and the arctangent table.
// ----------------------------------------------------------------------------
package upi_pkg;

    localparam int ANGLE_ITERS_DEF = 24;
    localparam logic [7:0] TIMEOUT_RESET = 8'd20;
    localparam logic [7:0] AGE_MAX = 8'd255;
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    localparam logic [1:0] CMD_VEL  = 2'd0;
    localparam logic [1:0] CMD_POSE = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    typedef struct packed {
        logic        [1:0]  cmd;
        logic signed [31:0] lin_velocity;
        logic signed [31:0] turn_rate;
        logic signed [31:0] set_x;
        logic signed [31:0] set_y;
        logic        [31:0] set_heading;
        logic        [47:0] time_now;
    } upi_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [31:0] heading;
        logic signed [31:0] speed_out;
        logic signed [31:0] rate_out;
        logic               timed_out;
    } upi_out_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_Y0, ST_Y1, ST_Y2, ST_Y3, ST_CORDIC,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_PUBLISH
    } upi_state_t;

    typedef enum logic [2:0] {
        MUL_NONE, MUL_YAW_DL, MUL_YAW_DH, MUL_VEL_TRIG,
        MUL_ALO_DL, MUL_ALO_DH, MUL_AHI_DL, MUL_AHI_DH
    } upi_mul_t;

    typedef enum logic [1:0] {
        ACC_NONE, ACC_LOAD, ACC_ADD
    } upi_acc_t;

    typedef struct packed {
        logic       load_in;
        logic       do_vel;
        logic       do_pose;
        logic       do_back;
        logic       do_tick;
        upi_mul_t   mul_sel;
        upi_acc_t   acc_op;
        logic [1:0] acc_sh;
        logic       save_angle;
        logic       cordic_step;
        logic [4:0] iter_idx;
        logic       save_a;
        logic       axis;
        logic       finish_axis;
        logic       publish;
    } upi_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       time_lt;
        logic       time_eq;
        logic       out_busy;
    } upi_stat_t;

    // atan(2^-i) in units of 2^-32 turn.
    function automatic logic [31:0] atan_turns(input logic [4:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

@@ design/upi_ctrl.sv @@
// ----------------------------------------------------------------------------
// Unicycle pose integrator controller
// Sequences decode, heading product, CORDIC rotations and position updates.
// ----------------------------------------------------------------------------
module upi_ctrl #(
    parameter int ANGLE_ITERS = upi_pkg::ANGLE_ITERS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  upi_pkg::upi_stat_t stat,
    output upi_pkg::upi_cmd_t  cmd
);
    import upi_pkg::*;

    localparam int IterW = (ANGLE_ITERS > 1) ? $clog2(ANGLE_ITERS) : 1;
    localparam logic [IterW-1:0] IterLast = IterW'(ANGLE_ITERS - 1);

    upi_state_t       state_reg, state_next;
    logic [IterW-1:0] cnt_reg, cnt_next;
    logic             axis_reg, axis_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (stat.kind)
                    CMD_POSE: state_next = ST_PUBLISH;
                    CMD_TICK: begin
                        if (stat.time_lt || stat.time_eq) begin
                            state_next = ST_IDLE;
                        end else begin
                            state_next = ST_Y0;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_Y0: state_next = ST_Y1;
            ST_Y1: state_next = ST_Y2;
            ST_Y2: state_next = ST_Y3;
            ST_Y3: begin
                state_next = ST_CORDIC;
                cnt_next   = '0;
            end
            ST_CORDIC: begin
                if (cnt_reg == IterLast) begin
                    state_next = ST_P0;
                    axis_next  = 1'b0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_P0: state_next = ST_P1;
            ST_P1: state_next = ST_P2;
            ST_P2: state_next = ST_P3;
            ST_P3: state_next = ST_P4;
            ST_P4: state_next = ST_P5;
            ST_P5: state_next = ST_P6;
            ST_P6: state_next = ST_P7;
            ST_P7: begin
                if (axis_reg) begin
                    state_next = ST_PUBLISH;
                end else begin
                    state_next = ST_P0;
                    axis_next  = 1'b1;
                end
            end
            ST_PUBLISH: begin
                if (!stat.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.mul_sel  = MUL_NONE;
        cmd.acc_op   = ACC_NONE;
        cmd.axis     = axis_reg;
        cmd.iter_idx = 5'(cnt_reg);
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_DECODE: begin
                unique case (stat.kind)
                    CMD_VEL:  cmd.do_vel = 1'b1;
                    CMD_POSE: cmd.do_pose = 1'b1;
                    CMD_TICK: begin
                        cmd.do_back = stat.time_lt;
                        cmd.do_tick = !stat.time_lt && !stat.time_eq;
                    end
                    default: ;
                endcase
            end
            ST_Y0: cmd.mul_sel = MUL_YAW_DL;
            ST_Y1: begin
                cmd.mul_sel = MUL_YAW_DH;
                cmd.acc_op  = ACC_LOAD;
                cmd.acc_sh  = 2'd0;
            end
            ST_Y2: begin
                cmd.acc_op = ACC_ADD;
                cmd.acc_sh = 2'd1;
            end
            ST_Y3:     cmd.save_angle = 1'b1;
            ST_CORDIC: cmd.cordic_step = 1'b1;
            ST_P0:     cmd.mul_sel = MUL_VEL_TRIG;
            ST_P1:     cmd.save_a = 1'b1;
            ST_P2:     cmd.mul_sel = MUL_ALO_DL;
            ST_P3: begin
                cmd.mul_sel = MUL_ALO_DH;
                cmd.acc_op  = ACC_LOAD;
                cmd.acc_sh  = 2'd0;
            end
            ST_P4: begin
                cmd.mul_sel = MUL_AHI_DL;
                cmd.acc_op  = ACC_ADD;
                cmd.acc_sh  = 2'd1;
            end
            ST_P5: begin
                cmd.mul_sel = MUL_AHI_DH;
                cmd.acc_op  = ACC_ADD;
                cmd.acc_sh  = 2'd1;
            end
            ST_P6: begin
                cmd.acc_op = ACC_ADD;
                cmd.acc_sh = 2'd2;
            end
            ST_P7:      cmd.finish_axis = 1'b1;
            ST_PUBLISH: cmd.publish = !stat.out_busy;
            default: ;
        endcase
    end

endmodule

@@ design/upi_datapath.sv @@
// ----------------------------------------------------------------------------
// Unicycle pose integrator datapath
// Pose state, shared 32x32 multiplier with accumulator, CORDIC and output.
// ----------------------------------------------------------------------------
module upi_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  upi_pkg::upi_in_t   s_data,
    input  logic               m_ready,
    output logic               m_valid,
    output upi_pkg::upi_out_t  m_data,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  upi_pkg::upi_cmd_t  cmd,
    output upi_pkg::upi_stat_t stat
);
    import upi_pkg::*;

    upi_in_t            in_reg;
    logic [7:0]         timeout_reg;
    logic [31:0]        x_reg, y_reg, yaw_reg, fwd_reg, rate_reg;
    logic [7:0]         age_reg;
    logic [47:0]        last_reg, dt_reg;
    logic               flag_reg;
    logic [63:0]        prod_reg, a_reg;
    logic [111:0]       acc_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               flip_reg, neg_reg;
    upi_out_t           out_reg;
    logic               m_valid_reg;

    logic [31:0]        mul_a, mul_b;
    logic [111:0]       acc_add;
    logic [63:0]        p64;
    logic [31:0]        half, dth, ang, ang_t, ang_f;
    logic signed [33:0] trig_sel, trig_s, trig_abs, dx, dy, atan_v;
    logic [31:0]        vel_mag, trig_mag, pos_sel, pos_new;
    logic [53:0]        q_mag;
    logic [32:0]        mag;
    logic signed [33:0] r_pos;

    assign stat.kind     = in_reg.cmd;
    assign stat.time_lt  = in_reg.time_now < last_reg;
    assign stat.time_eq  = in_reg.time_now == last_reg;
    assign stat.out_busy = m_valid_reg && !m_ready;

    assign vel_mag  = fwd_reg[31] ? (32'd0 - fwd_reg) : fwd_reg;
    assign trig_sel = cmd.axis ? cy_reg : cx_reg;
    assign trig_s   = flip_reg ? -trig_sel : trig_sel;
    assign trig_abs = trig_s[33] ? -trig_s : trig_s;
    assign trig_mag = trig_abs[31:0];

    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (cmd.mul_sel)
            MUL_YAW_DL: begin
                mul_a = rate_reg;
                mul_b = dt_reg[31:0];
            end
            MUL_YAW_DH: begin
                mul_a = rate_reg;
                mul_b = {16'd0, dt_reg[47:32]};
            end
            MUL_VEL_TRIG: begin
                mul_a = vel_mag;
                mul_b = trig_mag;
            end
            MUL_ALO_DL: begin
                mul_a = a_reg[31:0];
                mul_b = dt_reg[31:0];
            end
            MUL_ALO_DH: begin
                mul_a = a_reg[31:0];
                mul_b = {16'd0, dt_reg[47:32]};
            end
            MUL_AHI_DL: begin
                mul_a = a_reg[63:32];
                mul_b = dt_reg[31:0];
            end
            MUL_AHI_DH: begin
                mul_a = a_reg[63:32];
                mul_b = {16'd0, dt_reg[47:32]};
            end
            default: ;
        endcase
    end

    always_comb begin
        case (cmd.acc_sh)
            2'd1:    acc_add = {16'd0, prod_reg, 32'd0};
            2'd2:    acc_add = {prod_reg[47:0], 64'd0};
            default: acc_add = {48'd0, prod_reg};
        endcase
    end

    // The signed yaw rate times dt: the unsigned product less the sign
    // correction, of which only the part below bit 64 matters.
    assign p64   = acc_reg[63:0] - (rate_reg[31] ? {dt_reg[31:0], 32'd0} : 64'd0);
    assign half  = p64[44:13];
    assign dth   = p64[43:12];
    assign ang   = yaw_reg + half;
    assign ang_t = ang + 32'h40000000;
    assign ang_f = ang_t[31] ? (ang - 32'h80000000) : ang;

    assign dx     = cy_reg >>> cmd.iter_idx;
    assign dy     = cx_reg >>> cmd.iter_idx;
    assign atan_v = {2'b00, atan_turns(cmd.iter_idx)};

    // Product magnitude scaled by 2^-58, capped at one full unit above range.
    assign q_mag   = acc_reg[111:58];
    assign mag     = (q_mag > 54'h1_0000_0000) ? 33'h1_0000_0000 : q_mag[32:0];
    assign pos_sel = cmd.axis ? y_reg : x_reg;
    assign r_pos   = neg_reg ? ({{2{pos_sel[31]}}, pos_sel} - {1'b0, mag})
                             : ({{2{pos_sel[31]}}, pos_sel} + {1'b0, mag});
    always_comb begin
        if (r_pos > 34'sh0_7FFF_FFFF) begin
            pos_new = 32'h7FFFFFFF;
        end else if (r_pos < -34'sh0_8000_0000) begin
            pos_new = 32'h80000000;
        end else begin
            pos_new = r_pos[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        case (cmd.acc_op)
            ACC_LOAD: acc_reg <= acc_add;
            ACC_ADD:  acc_reg <= acc_reg + acc_add;
            default: ;
        endcase
        if (cmd.save_angle) begin
            cx_reg   <= 34'(CORDIC_GAIN_Q30);
            cy_reg   <= '0;
            cz_reg   <= {{2{ang_f[31]}}, ang_f};
            flip_reg <= ang_t[31];
        end
        if (cmd.cordic_step) begin
            if (!cz_reg[33]) begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - atan_v;
            end else begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + atan_v;
            end
        end
        if (cmd.save_a) begin
            a_reg   <= prod_reg;
            neg_reg <= fwd_reg[31] ^ trig_s[33];
        end
        if (cmd.publish) begin
            out_reg.pos_x     <= x_reg;
            out_reg.pos_y     <= y_reg;
            out_reg.heading   <= yaw_reg;
            out_reg.speed_out <= fwd_reg;
            out_reg.rate_out  <= rate_reg;
            out_reg.timed_out <= flag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            x_reg       <= '0;
            y_reg       <= '0;
            yaw_reg     <= '0;
            fwd_reg     <= '0;
            rate_reg    <= '0;
            age_reg     <= '0;
            last_reg    <= '0;
            dt_reg      <= '0;
            flag_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            if (cmd.do_vel) begin
                fwd_reg  <= in_reg.lin_velocity;
                rate_reg <= in_reg.turn_rate;
                age_reg  <= '0;
            end
            if (cmd.do_pose) begin
                x_reg    <= in_reg.set_x;
                y_reg    <= in_reg.set_y;
                yaw_reg  <= in_reg.set_heading;
                fwd_reg  <= '0;
                rate_reg <= '0;
                flag_reg <= 1'b0;
            end
            if (cmd.do_back) begin
                last_reg <= '0;
                age_reg  <= '0;
                fwd_reg  <= '0;
                rate_reg <= '0;
            end
            if (cmd.do_tick) begin
                dt_reg   <= in_reg.time_now - last_reg;
                last_reg <= in_reg.time_now;
                flag_reg <= age_reg > timeout_reg;
                if (age_reg > timeout_reg) begin
                    fwd_reg  <= '0;
                    rate_reg <= '0;
                end
            end
            if (cmd.save_angle) begin
                yaw_reg <= yaw_reg + dth;
            end
            if (cmd.finish_axis) begin
                if (cmd.axis) begin
                    y_reg <= pos_new;
                    if (age_reg != AGE_MAX) begin
                        age_reg <= age_reg + 8'd1;
                    end
                end else begin
                    x_reg <= pos_new;
                end
            end
            if (cmd.publish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ design/unicycle_pose_integrator.sv @@
// ----------------------------------------------------------------------------
// Unicycle pose integrator
// Dead-reckoning pose (x, y, heading) driven by velocity, pose and time items.
// ----------------------------------------------------------------------------
// Usage: items enter on s_valid/s_ready/s_data and results leave on
// m_valid/m_ready/m_data. A velocity command produces no result and keeps the
// block busy through decode. A pose item goes through decode and publish to
// the output register. An integrating time tick runs the heading product,
// ANGLE_ITERS CORDIC rotations (24 by default) and both position updates:
// one shared 32x32 multiplier carries the heading product and both position
// products, and the CORDIC unit does one rotation per cycle. A backward or
// repeated time tick returns to idle from decode. The block handles one item
// at a time; s_ready is high only when idle, and it rises again as soon as a
// result is in the output register, so the next item can enter while that
// result waits. If the receiver stalls, a new result waits in the controller
// until the output register is taken. cfg_wr_en/cfg_wr_data set the command
// timeout in ticks at once. Reset clears the pose, velocities, age and time
// base and sets the timeout to 20 ticks; no result is pending after reset.
// ----------------------------------------------------------------------------
module unicycle_pose_integrator #(
    parameter int ANGLE_ITERS = upi_pkg::ANGLE_ITERS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  upi_pkg::upi_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output upi_pkg::upi_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data
);
    import upi_pkg::*;

    upi_cmd_t  cmd;
    upi_stat_t stat;

    upi_ctrl #(
        .ANGLE_ITERS(ANGLE_ITERS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    upi_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

@@ design/upi_checker.sv @@
// ----------------------------------------------------------------------------
// Unicycle pose integrator port checker
// Watches the top level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "unicycle_pose_integrator_defines.svh"

module upi_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input upi_pkg::upi_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input upi_pkg::upi_out_t m_data
);
    import upi_pkg::*;

    // A stalled result must hold.
    `UPI_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // Nothing is pending right after reset.
    `UPI_ASSERT_RST(a_reset_clear, !aresetn, !m_valid, "result valid after reset")

    // A velocity command never makes a result.
    `UPI_ASSERT_NEXT(a_vel_silent, s_valid && s_ready && s_data.cmd == CMD_VEL && !m_valid, !m_valid ##1 !m_valid, "velocity command produced a result")

    // A pose item reports the pose it set.
    `UPI_ASSERT_NOW(a_pose_echo, s_valid && s_ready && s_data.cmd == CMD_POSE && !m_valid, ##3 (m_valid && m_data.pos_x == $past(s_data.set_x, 3) && m_data.heading == $past(s_data.set_heading, 3) && !m_data.timed_out), "pose item result mismatch")

endmodule

bind unicycle_pose_integrator upi_checker u_upi_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ tb/sv/upi_scoreboard.sv @@
// ----------------------------------------------------------------------------
// Unicycle pose integrator checker
// Watches both channels and the timeout register, works out the expected pose
// for every accepted item and compares each result field by field.
// ----------------------------------------------------------------------------
module upi_scoreboard #(
    parameter int ANGLE_ITERS = upi_pkg::ANGLE_ITERS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  upi_pkg::upi_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  upi_pkg::upi_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    output int                pending,
    output int                errors
);
    import upi_pkg::*;

    localparam logic [31:0] ATAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    logic [7:0]         timeout_ticks;
    logic signed [31:0] pose_x, pose_y, speed, rate;
    logic [31:0]        yaw;
    logic [7:0]         age;
    logic [47:0]        last_t;
    upi_out_t           pose_q[$];
    int                 mism;

    assign pending = pose_q.size();
    assign errors  = mism;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %h expected %h", what, got, exp);
        mism++;
    endtask

    // Cosine and sine of a binary angle in Q2.30.
    function automatic void rotate(input logic [31:0] ang, output longint c, output longint s);
        logic [31:0] t, a;
        bit flip;
        longint x, y, z, dx, dy;
        t = ang + 32'h40000000;
        flip = t[31];
        a = flip ? ang - 32'h80000000 : ang;
        z = longint'(signed'(a));
        x = 652032874;
        y = 0;
        for (int i = 0; i < ANGLE_ITERS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Position plus speed * trig * dt scaled to Q16.16, truncated toward zero.
    function automatic logic [31:0] move_axis(input logic [31:0] pos, input longint vel,
                                              input longint trig, input logic [47:0] dt);
        longint p, r;
        bit neg;
        bit [63:0] a;
        bit [127:0] full, mag;
        p = vel * trig;
        neg = p < 0;
        a = neg ? -p : p;
        full = {64'b0, a} * {80'b0, dt};
        mag = full >> 58;
        if (mag > 128'h1_0000_0000) mag = 128'h1_0000_0000;
        r = longint'(signed'(pos));
        r = neg ? r - longint'(mag[63:0]) : r + longint'(mag[63:0]);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic upi_out_t snapshot(input logic flag);
        upi_out_t o;
        o.pos_x = pose_x; o.pos_y = pose_y; o.heading = yaw;
        o.speed_out = speed; o.rate_out = rate; o.timed_out = flag;
        return o;
    endfunction

    task automatic integrate(input upi_in_t it);
        logic [47:0] dt;
        logic [63:0] prod;
        logic flag;
        longint c, s;
        if (it.cmd == CMD_VEL) begin
            speed = it.lin_velocity; rate = it.turn_rate; age = '0;
        end else if (it.cmd == CMD_POSE) begin
            pose_x = it.set_x; pose_y = it.set_y; yaw = it.set_heading;
            speed = '0; rate = '0;
            pose_q.push_back(snapshot(1'b0));
        end else if (it.cmd == CMD_TICK) begin
            if (it.time_now < last_t) begin
                last_t = '0; age = '0; speed = '0; rate = '0;
            end else if (it.time_now != last_t) begin
                dt = it.time_now - last_t;
                last_t = it.time_now;
                flag = 1'b0;
                if (age > timeout_ticks) begin
                    speed = '0; rate = '0; flag = 1'b1;
                end
                prod = longint'(rate) * longint'({16'b0, dt});
                rotate(yaw + prod[44:13], c, s);
                pose_x = move_axis(pose_x, longint'(speed), c, dt);
                pose_y = move_axis(pose_y, longint'(speed), s, dt);
                yaw += prod[43:12];
                if (age < AGE_MAX) age++;
                pose_q.push_back(snapshot(flag));
            end
        end
    endtask

    always @(posedge aclk) begin
        upi_out_t e;
        if (!aresetn) begin
            timeout_ticks <= TIMEOUT_RESET;
            pose_x = '0; pose_y = '0; yaw = '0; speed = '0; rate = '0;
            age = '0; last_t = '0;
            pose_q.delete();
            mism = 0;
        end else begin
            if (cfg_wr_en) timeout_ticks <= cfg_wr_data;
            if (m_valid && m_ready) begin
                if (pose_q.size() == 0) begin
                    report("unexpected result", m_data.pos_x, 32'd0);
                end else begin
                    e = pose_q.pop_front();
                    if (m_data.pos_x !== e.pos_x) report("pos_x", m_data.pos_x, e.pos_x);
                    if (m_data.pos_y !== e.pos_y) report("pos_y", m_data.pos_y, e.pos_y);
                    if (m_data.heading !== e.heading)
                        report("heading", m_data.heading, e.heading);
                    if (m_data.speed_out !== e.speed_out)
                        report("speed_out", m_data.speed_out, e.speed_out);
                    if (m_data.rate_out !== e.rate_out)
                        report("rate_out", m_data.rate_out, e.rate_out);
                    if (m_data.timed_out !== e.timed_out)
                        report("timed_out", {31'b0, m_data.timed_out}, {31'b0, e.timed_out});
                end
            end
            if (s_valid && s_ready) integrate(s_data);
        end
    end

endmodule

@@ tb/sv/tb_unicycle_pose_integrator.sv @@
// ----------------------------------------------------------------------------
// Unicycle pose integrator testbench
// Directed and random velocity, pose and time items under random stalls on
// both channels and several timeout settings; a side checker predicts results.
// ----------------------------------------------------------------------------
module tb_unicycle_pose_integrator;
    import upi_pkg::*;

    localparam int STALL_LIMIT = 6000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    upi_in_t    s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    upi_out_t   m_data;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = '0;
    int         pending, errors;
    int         idle_cycles = 0;
    int         item_no = 0;
    logic [47:0] tb_time = '0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    unicycle_pose_integrator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    upi_scoreboard chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .pending(pending), .errors(errors)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic upi_in_t noise_item(input logic [1:0] kind);
        upi_in_t it;
        it.cmd          = kind;
        it.lin_velocity = $urandom;
        it.turn_rate    = $urandom;
        it.set_x        = $urandom;
        it.set_y        = $urandom;
        it.set_heading  = $urandom;
        it.time_now     = 48'({$urandom, $urandom});
        return it;
    endfunction

    function automatic upi_in_t vel_item(input logic [31:0] v, input logic [31:0] r);
        upi_in_t it;
        it = noise_item(CMD_VEL);
        it.lin_velocity = v; it.turn_rate = r;
        return it;
    endfunction

    function automatic upi_in_t pose_item(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] h);
        upi_in_t it;
        it = noise_item(CMD_POSE);
        it.set_x = x; it.set_y = y; it.set_heading = h;
        return it;
    endfunction

    // The block drops its time base to zero on a backward tick.
    function automatic upi_in_t tick_at(input logic [47:0] t);
        upi_in_t it;
        it = noise_item(CMD_TICK);
        it.time_now = t;
        tb_time = (t < tb_time) ? '0 : t;
        return it;
    endfunction

    task automatic send(input upi_in_t it, input bit no_gaps);
        int gap;
        s_data <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        item_no++;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_and_write(input logic [7:0] v);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        // Ignored ticks leave no result but can still keep the block busy.
        repeat (60) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic upi_in_t random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            if ($urandom_range(0, 1))
                return vel_item($urandom_range(0, 32'h07FFFFFF) - 32'h04000000,
                                $urandom_range(0, 32'h07FFFFFF) - 32'h04000000);
            return vel_item($urandom, $urandom);
        end
        if (r < 27) return pose_item($urandom, $urandom, $urandom);
        if (r < 30) return noise_item(2'd3);
        if (r < 33 && tb_time != 0) return tick_at(tb_time - $urandom_range(1, 1000));
        if (r < 36) return tick_at(tb_time);
        if (r < 38) return tick_at(48'({$urandom, $urandom}));
        if (r < 41) return tick_at(tb_time + $urandom);
        return tick_at(tb_time + $urandom_range(1, 4096));
    endfunction

    // Receiver: random stalls, one long hold-off while the sender keeps going.
    initial begin
        int taken, gap;
        taken = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken == 60) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                taken++;
            end
            gap = ((taken / 50) % 4 == 1) ? 0 : pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (taken != 60) taken++;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [7:0] settings [4];
        settings = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 40))};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, item kinds and the special cases.
        send(tick_at(48'd0), 0);                     // same time as reset base
        send(vel_item(32'h7FFFFFFF, 32'h80000000), 0);
        send(tick_at(48'd1), 0);
        send(pose_item(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF), 0);
        send(vel_item(32'h7FFFFFFF, 32'h7FFFFFFF), 0);
        send(tick_at(48'd1000), 0);
        send(tick_at(48'hFFFF_FFFF_FFFF), 0);        // huge step saturates
        send(tick_at(48'd5), 0);                     // backward time
        send(noise_item(2'd3), 0);
        send(pose_item(32'h0, 32'h0, 32'h80000000), 0);
        send(vel_item(32'h80000000, 32'h01000000), 0);
        send(tick_at(48'd500), 0);
        send(tick_at(48'd500), 0);
        send(pose_item(32'h80000000, 32'h7FFFFFFF, 32'h40000000), 0);
        send(vel_item(32'h01000000, 32'hFF000000), 0);
        send(tick_at(48'd100000), 0);
        send(pose_item(32'h00010000, 32'hFFFF0000, 32'hC0000000), 0);
        send(vel_item(32'h00800000, 32'h00000000), 0);
        send(tick_at(48'd200000), 0);
        send(tick_at(48'd200001), 0);

        for (int ph = 0; ph < 4; ph++) begin
            drain_and_write(settings[ph]);
            for (int i = 0; i < 170; i++) send(random_item(), (i % 100) < 20);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
